// File: rtl/vst_pkg.sv
// ----------------------------------------------------------------------------
// vst_pkg
// Types and constants shared by the version string tokenizer modules.
// ----------------------------------------------------------------------------
package vst_pkg;

   localparam int VALUE_W    = 32;
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_DOT     = 8'h2e;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [0:0] {
      ACTION_CHAR = 1'b0,
      ACTION_END  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      KIND_NUMBER = 2'd0,
      KIND_LETTER = 2'd1,
      KIND_DONE   = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      FAULT_NONE    = 2'd0,
      FAULT_EMPTY   = 2'd1,
      FAULT_INVALID = 2'd2,
      FAULT_NOCOMP  = 2'd3
   } fault_type;

   typedef enum logic [1:0] {
      CLS_START  = 2'd0,
      CLS_DIGIT  = 2'd1,
      CLS_LETTER = 2'd2,
      CLS_DOT    = 2'd3
   } class_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  ch;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      logic [VALUE_W-1:0]  value;
      fault_type           fault;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  count;
      rsp_type     first;
      rsp_type     second;
   } push_type;

endpackage

// File: rtl/version_string_tokenizer_top.sv
// ----------------------------------------------------------------------------
// version_string_tokenizer_top
// Splits a version string, one character per item, into number and letter
// components and closes each string with a done or rejected result.
//
//   Channel  Direction  Carries
//   req      in         one character or the end of string marker
//   rsp      out        number, letter, done or rejected result
//
// A character is registered when accepted and decided from that register
// once the queue has room. Its results enter a four entry queue that sends
// one result per cycle while rsp_stall is low, so the two results of one
// item leave one after the other. Input is taken every cycle while the
// queue has space for two results. Reset clears the tokenizer state and
// empties the queue. Result stalls back up via the queue into req_stall.
// ----------------------------------------------------------------------------
module version_string_tokenizer_top import vst_pkg::*; #(
   parameter int NUM_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   push_type push;
   logic     room;

   vst_core #(
      .NUM_BITS (NUM_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .room      (room),
      .push      (push)
   );

   vst_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/vst_core.sv
// ----------------------------------------------------------------------------
// vst_core
// Input register, tokenizer state and per-character decision logic. Emits up
// to two results per item toward the result queue.
// ----------------------------------------------------------------------------
module vst_core import vst_pkg::*; #(
   parameter int NUM_BITS = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  logic     room,
   output push_type push
);

   logic                    in_valid_ff, in_valid_in;
   req_type                 in_item_ff;
   logic                    accept;
   logic                    advance;

   logic                    in_number_ff, in_number_in;
   logic [NUM_BITS-1:0]     acc_ff, acc_in;
   logic                    ovf_ff, ovf_in;
   class_type               prev_ff, prev_in;
   logic                    saw_ff, saw_in;
   fault_type               fault_ff, fault_in;

   logic [7:0]              ch;
   logic                    is_digit;
   logic                    is_dot;
   logic                    is_letter;
   logic [7:0]              lower_ch;
   logic [3:0]              digit;
   logic [NUM_BITS+3:0]     acc_ext;
   logic [NUM_BITS+3:0]     product;
   logic                    ovf_now;
   logic [VALUE_W+NUM_BITS-1:0] acc_wide;
   rsp_type                 num_res;
   rsp_type                 let_res;
   rsp_type                 end_res;
   fault_type               end_fault;

   assign req_stall   = in_valid_ff && !room;
   assign accept      = req_valid && !req_stall;
   assign advance     = in_valid_ff && room;
   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_data;
      end
   end

   assign ch        = in_item_ff.ch;
   assign is_digit  = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   assign is_dot    = (ch == CHAR_DOT);
   assign lower_ch  = ((ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_Z)) ? ch + CASE_OFFSET : ch;
   assign is_letter = (lower_ch >= CHAR_LOWER_A) && (lower_ch <= CHAR_LOWER_Z);
   assign digit     = 4'(ch - CHAR_ZERO);

   assign acc_ext = {4'b0000, acc_ff};
   assign product = (acc_ext << 3) + (acc_ext << 1) + {{NUM_BITS{1'b0}}, digit};
   assign ovf_now = |product[NUM_BITS+3:NUM_BITS];

   assign acc_wide = {{VALUE_W{1'b0}}, acc_ff};

   always_comb begin
      num_res.kind  = KIND_NUMBER;
      num_res.value = ovf_ff ? '0 : acc_wide[VALUE_W-1:0];
      num_res.fault = FAULT_NONE;
      num_res.last  = 1'b0;

      let_res.kind  = KIND_LETTER;
      let_res.value = {{(VALUE_W-8){1'b0}}, lower_ch};
      let_res.fault = FAULT_NONE;
      let_res.last  = 1'b0;
   end

   always_comb begin
      end_fault = fault_ff;
      if (fault_ff == FAULT_NONE) begin
         if (prev_ff == CLS_DOT) begin
            end_fault = FAULT_EMPTY;
         end else if (!saw_ff && !in_number_ff) begin
            end_fault = FAULT_NOCOMP;
         end
      end
      end_res.kind  = (end_fault == FAULT_NONE) ? KIND_DONE : KIND_REJECT;
      end_res.value = '0;
      end_res.fault = end_fault;
      end_res.last  = 1'b1;
   end

   always_comb begin
      in_number_in = in_number_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      prev_in      = prev_ff;
      saw_in       = saw_ff;
      fault_in     = fault_ff;
      push.count   = 2'd0;
      push.first   = num_res;
      push.second  = end_res;

      if (advance) begin
         if (in_item_ff.action == ACTION_END) begin
            if ((fault_ff == FAULT_NONE) && in_number_ff) begin
               push.count  = 2'd2;
               push.first  = num_res;
               push.second = end_res;
            end else begin
               push.count = 2'd1;
               push.first = end_res;
            end
            in_number_in = 1'b0;
            acc_in       = '0;
            ovf_in       = 1'b0;
            prev_in      = CLS_START;
            saw_in       = 1'b0;
            fault_in     = FAULT_NONE;
         end else if (fault_ff == FAULT_NONE) begin
            if (is_digit) begin
               if (!ovf_ff) begin
                  if (ovf_now) begin
                     ovf_in = 1'b1;
                  end else begin
                     acc_in = product[NUM_BITS-1:0];
                  end
               end
               in_number_in = 1'b1;
               prev_in      = CLS_DIGIT;
            end else if (is_dot) begin
               if (in_number_ff) begin
                  push.count   = 2'd1;
                  push.first   = num_res;
                  in_number_in = 1'b0;
                  acc_in       = '0;
                  ovf_in       = 1'b0;
                  saw_in       = 1'b1;
               end else if ((prev_ff == CLS_START) || (prev_ff == CLS_DOT)) begin
                  fault_in = FAULT_EMPTY;
               end
               prev_in = CLS_DOT;
            end else if (is_letter) begin
               if (in_number_ff) begin
                  push.count  = 2'd2;
                  push.first  = num_res;
                  push.second = let_res;
               end else begin
                  push.count = 2'd1;
                  push.first = let_res;
               end
               in_number_in = 1'b0;
               acc_in       = '0;
               ovf_in       = 1'b0;
               saw_in       = 1'b1;
               prev_in      = CLS_LETTER;
            end else begin
               fault_in = FAULT_INVALID;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_number_ff <= 1'b0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         prev_ff      <= CLS_START;
         saw_ff       <= 1'b0;
         fault_ff     <= FAULT_NONE;
      end else begin
         in_number_ff <= in_number_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         prev_ff      <= prev_in;
         saw_ff       <= saw_in;
         fault_ff     <= fault_in;
      end
   end

endmodule

// File: rtl/vst_fifo.sv
// ----------------------------------------------------------------------------
// vst_fifo
// Small result queue. Takes up to two results per cycle and hands out one
// result per cycle on the result channel while rsp_stall is low.
// ----------------------------------------------------------------------------
module vst_fifo import vst_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   rsp_type               entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [PTR_W-1:0]      wr_next;
   logic                  pop;

   assign room      = (count_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_next   = wr_ptr_ff + PTR_W'(1);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Version string tokenizer testbench
// Sends version strings one character at a time, each closed by an end item,
// and checks every number, letter, done and rejected result against a
// tokenizer model kept in the testbench. Directed strings cover the faults
// and the number limits. Random strings then run under several idle and
// stall mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench import vst_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BITS = 32;
   localparam logic [63:0] NUM_MAX = {64{1'b1}} >> (64 - NUM_BITS);
   localparam int RESET_CYCLES = 9;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 12;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int REPORT_LIMIT = 200;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_ticket = 0;
   int hold_served = 0;
   int hold_count = 0;
   int idle_cycles = 0;
   int items_sent = 0;
   int mismatches = 0;

   logic [7:0] string_buf[$];
   rsp_type    expected_components[$];

   logic        tok_in_number = 1'b0;
   logic [63:0] tok_acc = '0;
   logic        tok_overflow = 1'b0;
   class_type   tok_prev = CLS_START;
   logic        tok_saw = 1'b0;
   fault_type   tok_fault = FAULT_NONE;

   version_string_tokenizer_top #(
      .NUM_BITS(NUM_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void append_char(input logic [7:0] c);
      string_buf.insert(string_buf.size(), c);
   endfunction

   function automatic void expect_result(kind_type kind, logic [31:0] value, fault_type fault,
                                         logic last);
      rsp_type r;
      r.kind = kind;
      r.value = value;
      r.fault = fault;
      r.last = last;
      expected_components.insert(expected_components.size(), r);
   endfunction

   function automatic void emit_number();
      expect_result(KIND_NUMBER, tok_overflow ? 32'd0 : tok_acc[31:0], FAULT_NONE, 1'b0);
      tok_in_number = 1'b0;
      tok_acc = '0;
      tok_overflow = 1'b0;
      tok_saw = 1'b1;
   endfunction

   function automatic void clear_tokenizer();
      tok_in_number = 1'b0;
      tok_acc = '0;
      tok_overflow = 1'b0;
      tok_prev = CLS_START;
      tok_saw = 1'b0;
      tok_fault = FAULT_NONE;
   endfunction

   function automatic void tokenize_item(req_type item);
      logic [7:0]  lc;
      logic [63:0] d;
      fault_type   f;
      if (item.action == ACTION_END) begin
         f = tok_fault;
         if (f == FAULT_NONE) begin
            if (tok_in_number) emit_number();
            if (tok_prev == CLS_DOT) f = FAULT_EMPTY;
            else if (!tok_saw) f = FAULT_NOCOMP;
         end
         if (f == FAULT_NONE) expect_result(KIND_DONE, 32'd0, FAULT_NONE, 1'b1);
         else expect_result(KIND_REJECT, 32'd0, f, 1'b1);
         clear_tokenizer();
      end else if (tok_fault == FAULT_NONE) begin
         if (item.ch >= CHAR_ZERO && item.ch <= CHAR_NINE) begin
            d = 64'(item.ch - CHAR_ZERO);
            if (!tok_overflow) begin
               if (tok_acc > (NUM_MAX - d) / 10) tok_overflow = 1'b1;
               else tok_acc = tok_acc * 10 + d;
            end
            tok_in_number = 1'b1;
            tok_prev = CLS_DIGIT;
         end else if (item.ch == CHAR_DOT) begin
            if (tok_in_number) emit_number();
            else if (tok_prev == CLS_START || tok_prev == CLS_DOT) tok_fault = FAULT_EMPTY;
            tok_prev = CLS_DOT;
         end else begin
            lc = (item.ch >= CHAR_UPPER_A && item.ch <= CHAR_UPPER_Z) ?
                 item.ch + CASE_OFFSET : item.ch;
            if (lc >= CHAR_LOWER_A && lc <= CHAR_LOWER_Z) begin
               if (tok_in_number) emit_number();
               expect_result(KIND_LETTER, {24'd0, lc}, FAULT_NONE, 1'b0);
               tok_saw = 1'b1;
               tok_prev = CLS_LETTER;
            end else begin
               tok_fault = FAULT_INVALID;
            end
         end
      end
   endfunction

   task automatic send_item(input action_type act, input logic [7:0] c);
      req_type item;
      item.action = act;
      item.ch = c;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tokenize_item(item);
      items_sent++;
   endtask

   task automatic send_string();
      foreach (string_buf[i]) send_item(ACTION_CHAR, string_buf[i]);
      send_item(ACTION_END, 8'($urandom_range(255)));
   endtask

   function automatic void load_text(input string s);
      string_buf.delete();
      for (int i = 0; i < s.len(); i++) append_char(s[i]);
   endfunction

   function automatic void build_version_string();
      int         parts;
      int         len;
      int         pos;
      logic [7:0] c;
      string_buf.delete();
      parts = $urandom_range(1, 5);
      for (int p = 0; p < parts; p++) begin
         if (p > 0 && $urandom_range(3) != 0) append_char(CHAR_DOT);
         if ($urandom_range(2) != 0) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
            repeat (len) append_char(8'(CHAR_ZERO + $urandom_range(9)));
         end else begin
            c = 8'(CHAR_LOWER_A + $urandom_range(25));
            if ($urandom_range(1)) c = c - CASE_OFFSET;
            append_char(c);
         end
      end
      if ($urandom_range(99) < 15) begin
         pos = $urandom_range(string_buf.size());
         case ($urandom_range(3))
            0: begin
               string_buf.delete();
            end
            1: begin
               string_buf.insert(pos, CHAR_DOT);
            end
            2: begin
               string_buf[$urandom_range(string_buf.size() - 1)] = 8'($urandom_range(255));
            end
            default: begin
               append_char(CHAR_DOT);
            end
         endcase
      end
   endfunction

   task automatic report_mismatch(input string field, input longint unsigned want,
                                  input longint unsigned got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_components.size() == 0) begin
            report_mismatch("unexpected result kind", 0, rsp_data.kind);
         end else begin
            want = expected_components.pop_front();
            if (rsp_data.kind !== want.kind) report_mismatch("kind", want.kind, rsp_data.kind);
            if (rsp_data.value !== want.value)
               report_mismatch("value", want.value, rsp_data.value);
            if (rsp_data.fault !== want.fault)
               report_mismatch("fault", want.fault, rsp_data.fault);
            if (rsp_data.last !== want.last) report_mismatch("last", want.last, rsp_data.last);
         end
      end
   end

   always @(negedge clock) begin
      if (hold_count > 0) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count - 1;
      end else if (hold_ticket != hold_served) begin
         hold_served <= hold_ticket;
         hold_count <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_directed();
      load_text("");
      send_string();
      load_text(".");
      send_string();
      load_text("9Z.");
      send_string();
      load_text("0..");
      send_string();
      string_buf = '{8'hff, CHAR_NINE};
      send_string();
      string_buf = '{8'h00};
      send_string();
      load_text("a7");
      send_string();
      load_text("1.b");
      send_string();
   endtask

   task automatic test_wide_numbers();
      load_text("4294967295");
      send_string();
      load_text("4294967296");
      send_string();
      load_text("00000000004294967295.18446744073709551616");
      send_string();
      repeat (12) begin
         string_buf.delete();
         repeat ($urandom_range(9, 12)) append_char(8'(CHAR_ZERO + $urandom_range(9)));
         send_string();
      end
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_mix, input int count);
      int stop_at;
      send_idle_pct = idle_pct;
      stall_pct = stall_mix;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         build_version_string();
         send_string();
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_ticket++;
      repeat (12) begin
         build_version_string();
         send_string();
      end
   endtask

   initial begin
      clear_tokenizer();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_wide_numbers();
      test_random_traffic(0, 0, 400);
      test_random_traffic(72, 0, 400);
      test_random_traffic(0, 72, 400);
      test_random_traffic(25, 25, 400);
      test_backpressure();
      @(negedge clock);
      req_valid <= 1'b0;
      stall_pct = 0;
      while (expected_components.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/vst_pkg.sv
rtl/vst_core.sv
rtl/vst_fifo.sv
rtl/version_string_tokenizer_top.sv
tb/testbench.sv
